// File: sv/pixel_subtract_threshold_integrate_core_macros.svh
// Assertion macros shared by the pixel pipeline modules.
// With SYNTH defined every macro expands to nothing.
`ifndef PIXEL_SUBTRACT_THRESHOLD_INTEGRATE_CORE_MACROS_SVH
`define PIXEL_SUBTRACT_THRESHOLD_INTEGRATE_CORE_MACROS_SVH
`ifndef SYNTH
// The condition must never be true at a clock edge outside reset.
`define PSTI_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
// The consequent must hold in the same cycle as the antecedent.
`define PSTI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// The consequent must hold in the cycle after the antecedent.
`define PSTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define PSTI_ASSERT_NEVER(label, clk, rst, cond)
`define PSTI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PSTI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/psti_pkg.sv
package psti_pkg;

  localparam int FRAME_PIXELS = 307200;
  localparam int COUNT_BITS   = 16;

  localparam int POS_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int ACC_W = 8 + COUNT_BITS;

  localparam logic [POS_W-1:0]      LAST_POS  = POS_W'(FRAME_PIXELS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [7:0]            PIX_MAX   = 8'd255;

  // Queue between the front and the back, and the result queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int OUT_DEPTH   = 2;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);

  // Item function codes.
  localparam logic [1:0] FUNC_LOAD_REF = 2'd0;
  localparam logic [1:0] FUNC_PROCESS  = 2'd1;
  localparam logic [1:0] FUNC_RESTART  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_SUBTRACT_ENABLE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_ENABLE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT_ENABLE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEGRATE_ENABLE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_LEVEL  = 3'd4;

  typedef struct packed {
    logic       subtract;
    logic       threshold;
    logic       invert;
    logic       integrate;
    logic [7:0] level;
  } cfg_t;

  // One queued work item: a reference load or a pixel to process.
  typedef struct packed {
    logic                  is_load;
    logic [7:0]            pixel;
    logic                  last;
    logic [POS_W-1:0]      pos;
    logic                  first;
    logic                  sat;
    logic [COUNT_BITS-1:0] divisor;
  } work_t;

  typedef struct packed {
    logic                  need_div;
    logic [ACC_W-1:0]      dividend;
    logic [COUNT_BITS-1:0] divisor;
    logic [7:0]            pixel;
    logic                  last;
  } div_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } result_t;

endpackage

// File: sv/psti_front.sv
`include "pixel_subtract_threshold_integrate_core_macros.svh"

module psti_front (
  input  logic             clk,
  input  logic             rst,
  input  psti_pkg::cfg_t   cfg,
  input  logic             accept,
  input  logic [1:0]       func,
  input  logic [7:0]       pixel,
  input  logic             frame_end,
  output logic             q_wr,
  output psti_pkg::work_t  q_data
);
  import psti_pkg::*;

  logic [POS_W-1:0]      pos, pos_next;
  logic [COUNT_BITS-1:0] frames_done, frames_done_next;
  logic [POS_W-1:0]      pos_adv;
  logic                  is_sat;

  always_comb begin
    is_sat  = (frames_done == COUNT_MAX);
    pos_adv = (frame_end || pos == LAST_POS) ? '0 : pos + 1'b1;

    q_data.is_load = (func == FUNC_LOAD_REF);
    q_data.pixel   = pixel;
    q_data.last    = frame_end;
    q_data.pos     = pos;
    q_data.first   = (frames_done == '0);
    q_data.sat     = is_sat;
    q_data.divisor = is_sat ? COUNT_MAX : frames_done + 1'b1;

    q_wr             = 1'b0;
    pos_next         = pos;
    frames_done_next = frames_done;
    if (accept) begin
      unique case (func)
        FUNC_LOAD_REF: begin
          q_wr     = 1'b1;
          pos_next = pos_adv;
        end
        FUNC_PROCESS: begin
          q_wr     = 1'b1;
          pos_next = pos_adv;
          if (cfg.integrate && frame_end && !is_sat) begin
            frames_done_next = frames_done + 1'b1;
          end
        end
        FUNC_RESTART: begin
          pos_next         = '0;
          frames_done_next = '0;
        end
        default: begin
          pos_next = pos;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      frames_done <= '0;
    end else begin
      pos         <= pos_next;
      frames_done <= frames_done_next;
    end
  end

  `PSTI_ASSERT_NEVER(a_pos_in_frame, clk, rst, 32'(pos) >= FRAME_PIXELS)
  `PSTI_ASSERT_NEXT(a_restart_clears, clk, rst, accept && func == FUNC_RESTART, pos == '0 && frames_done == '0)

endmodule

// File: sv/psti_queue.sv
`include "pixel_subtract_threshold_integrate_core_macros.svh"

module psti_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  psti_pkg::work_t  wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output psti_pkg::work_t  rd_data
);
  import psti_pkg::*;

  work_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr, rptr;
  logic [QPTR_W:0]     cnt;

  assign full     = (cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= rptr + 1'b1;
      end
      cnt <= cnt + (QPTR_W + 1)'(wr_en) - (QPTR_W + 1)'(rd_en);
    end
  end

  `PSTI_ASSERT_NEVER(a_no_overflow, clk, rst, wr_en && full)

endmodule

// File: sv/psti_div.sv
module psti_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  psti_pkg::div_item_t in_item,
  output logic                tail_valid,
  output psti_pkg::result_t   tail
);
  import psti_pkg::*;

  // One restoring quotient bit per stage; dq holds the unused dividend
  // bits on the left and the quotient bits built up on the right.
  typedef struct packed {
    logic                  need_div;
    logic [COUNT_BITS-1:0] rem;
    logic [ACC_W-1:0]      dq;
    logic [COUNT_BITS-1:0] divisor;
    logic [7:0]            pixel;
    logic                  last;
  } stage_t;

  stage_t           stg [ACC_W];
  stage_t           nxt [ACC_W];
  logic [ACC_W-1:0] vld;

  function automatic stage_t div_step(input stage_t s);
    stage_t          r;
    logic [COUNT_BITS:0] trial;
    logic            ge;
    r     = s;
    trial = {s.rem, s.dq[ACC_W-1]};
    ge    = (trial >= {1'b0, s.divisor});
    r.rem = ge ? COUNT_BITS'(trial - {1'b0, s.divisor}) : trial[COUNT_BITS-1:0];
    r.dq  = {s.dq[ACC_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    stage_t head;
    head.need_div = in_item.need_div;
    head.rem      = '0;
    head.dq       = in_item.dividend;
    head.divisor  = in_item.divisor;
    head.pixel    = in_item.pixel;
    head.last     = in_item.last;
    for (int s = 0; s < ACC_W; s++) begin
      nxt[s] = div_step((s == 0) ? head : stg[(s == 0) ? 0 : s - 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int s = 0; s < ACC_W; s++) begin
        stg[s] <= nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[ACC_W-2:0], in_valid};
    end
  end

  assign tail_valid = vld[ACC_W-1];
  assign tail.pixel = stg[ACC_W-1].need_div ? stg[ACC_W-1].dq[7:0] : stg[ACC_W-1].pixel;
  assign tail.last  = stg[ACC_W-1].last;

endmodule

// File: sv/psti_back.sv
`include "pixel_subtract_threshold_integrate_core_macros.svh"

module psti_back (
  input  logic               clk,
  input  logic               rst,
  input  psti_pkg::cfg_t     cfg,
  input  logic               head_valid,
  input  psti_pkg::work_t    head,
  output logic               head_pop,
  output logic               empty,
  input  logic               pop,
  output psti_pkg::result_t  out_data
);
  import psti_pkg::*;

  // Per-pixel stores.
  logic [7:0]       ref_mem [FRAME_PIXELS];
  logic [ACC_W-1:0] acc_mem [FRAME_PIXELS];

  // Access stage registers.
  work_t            b1;
  logic             b1_vld;
  logic [7:0]       ref_rd, ref_fwd_data;
  logic             ref_fwd;
  logic [ACC_W-1:0] acc_rd, acc_fwd_data;
  logic             acc_fwd;

  logic             advance;
  logic             ref_we, acc_we;
  logic [ACC_W-1:0] acc_wdata;
  logic [7:0]       ref_val;
  logic [ACC_W-1:0] acc_val;
  logic [7:0]       p_sub, p_thr, p_inv, r_or;
  logic [ACC_W-1:0] sum;
  div_item_t        div_in;
  logic             div_in_valid;
  logic             tail_valid;
  result_t          tail;

  // Result queue.
  result_t          oq [OUT_DEPTH];
  logic [OPTR_W-1:0] owptr, orptr;
  logic [OPTR_W:0]  ocnt;
  logic             out_push, out_pop, out_full;

  assign out_full = (ocnt == (OPTR_W + 1)'(OUT_DEPTH));
  assign advance  = !(tail_valid && out_full);
  assign head_pop = advance && head_valid;

  always_comb begin
    ref_val = ref_fwd ? ref_fwd_data : ref_rd;
    acc_val = acc_fwd ? acc_fwd_data : acc_rd;

    p_sub = b1.pixel;
    if (cfg.subtract) begin
      p_sub = (b1.pixel >= ref_val) ? b1.pixel - ref_val : ref_val - b1.pixel;
    end
    p_thr = cfg.threshold ? ((p_sub > cfg.level) ? PIX_MAX : 8'd0) : p_sub;
    p_inv = cfg.invert ? ~p_thr : p_thr;

    r_or = (b1.first || p_inv == PIX_MAX || acc_val == ACC_W'(PIX_MAX)) ?
           (b1.first ? p_inv : PIX_MAX) : p_inv;
    sum  = acc_val + ACC_W'(p_inv);

    div_in.need_div = 1'b0;
    div_in.dividend = sum;
    div_in.divisor  = b1.divisor;
    div_in.pixel    = p_inv;
    div_in.last     = b1.last;
    acc_wdata       = ACC_W'(p_inv);
    acc_we          = 1'b0;
    if (cfg.integrate) begin
      priority if (cfg.threshold) begin
        div_in.pixel = r_or;
        acc_wdata    = ACC_W'(r_or);
        acc_we       = 1'b1;
      end else if (b1.first) begin
        acc_we = 1'b1;
      end else if (b1.sat) begin
        div_in.need_div = 1'b1;
        div_in.dividend = acc_val;
      end else begin
        div_in.need_div = 1'b1;
        acc_wdata       = sum;
        acc_we          = 1'b1;
      end
    end
    acc_we       = acc_we && advance && b1_vld && !b1.is_load;
    ref_we       = advance && b1_vld && b1.is_load;
    div_in_valid = b1_vld && !b1.is_load;
  end

  // Stores: read at the head address as it moves in, written as the item
  // leaves. A write to the same address in that cycle is forwarded.
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[b1.pos] <= b1.pixel;
    end
    if (head_pop) begin
      ref_rd <= ref_mem[head.pos];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[b1.pos] <= acc_wdata;
    end
    if (head_pop) begin
      acc_rd <= acc_mem[head.pos];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b1           <= head;
      ref_fwd      <= ref_we && (b1.pos == head.pos);
      ref_fwd_data <= b1.pixel;
      acc_fwd      <= acc_we && (b1.pos == head.pos);
      acc_fwd_data <= acc_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
    end else if (advance) begin
      b1_vld <= head_valid;
    end
  end

  psti_div u_div (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (div_in_valid),
    .in_item    (div_in),
    .tail_valid (tail_valid),
    .tail       (tail)
  );

  assign out_push = advance && tail_valid;
  assign empty    = (ocnt == '0);
  assign out_pop  = pop && !empty;
  assign out_data = oq[orptr];

  always_ff @(posedge clk) begin
    if (out_push) begin
      oq[owptr] <= tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr <= '0;
      orptr <= '0;
      ocnt  <= '0;
    end else begin
      if (out_push) begin
        owptr <= owptr + 1'b1;
      end
      if (out_pop) begin
        orptr <= orptr + 1'b1;
      end
      ocnt <= ocnt + (OPTR_W + 1)'(out_push) - (OPTR_W + 1)'(out_pop);
    end
  end

  `PSTI_ASSERT_NEVER(a_outq_overflow, clk, rst, out_push && out_full)
  `PSTI_ASSERT_IMPLY(a_divisor_nonzero, clk, rst, div_in_valid && div_in.need_div, div_in.divisor != '0)

endmodule

// File: sv/pixel_subtract_threshold_integrate_core.sv
// Channel   Direction  Handshake         Payload
// input     in         push / full       func, pixel, frame_end
// result    out        empty / pop       result_pixel, out_frame_end
// config    in         cfg_we            cfg_addr, cfg_wdata
//
// One item is taken per cycle, sustained, while full is low, and one result
// leaves per cycle while results are popped. A pixel passes the queue,
// the access stage, the divider pipeline, which resolves one quotient bit
// per stage over the full accumulator width, and the result queue.
// Reset clears the queues, pixel position, frame count and enables, sets
// the level to 128; the reference and accumulator stores are not cleared.
// A result that is not popped stalls the back part; the queue between the
// parts then fills and raises full.
module pixel_subtract_threshold_integrate_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      func,
  input  logic [7:0]                      pixel,
  input  logic                            frame_end,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      result_pixel,
  output logic                            out_frame_end,
  input  logic                            cfg_we,
  input  logic [psti_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [psti_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import psti_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    q_wr;
  work_t   q_wdata;
  logic    q_rd_valid;
  work_t   q_rdata;
  logic    q_rd;
  result_t out_data;

  // Configuration registers. Single-bit enables take bit zero of the data;
  // a write to an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.subtract  <= 1'b0;
      cfg.threshold <= 1'b0;
      cfg.invert    <= 1'b0;
      cfg.integrate <= 1'b0;
      cfg.level     <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SUBTRACT_ENABLE:  cfg.subtract  <= cfg_wdata[0];
        REG_THRESHOLD_ENABLE: cfg.threshold <= cfg_wdata[0];
        REG_INVERT_ENABLE:    cfg.invert    <= cfg_wdata[0];
        REG_INTEGRATE_ENABLE: cfg.integrate <= cfg_wdata[0];
        REG_THRESHOLD_LEVEL:  cfg.level     <= cfg_wdata[7:0];
        default: begin
          cfg.level <= cfg.level;
        end
      endcase
    end
  end

  // Every input transfer is taken by the front part. Restart and unused
  // codes act there and go no further; loads and pixels are queued with
  // their position and a snapshot of the frame count.
  assign accept = push && !full;

  psti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .func      (func),
    .pixel     (pixel),
    .frame_end (frame_end),
    .q_wr      (q_wr),
    .q_data    (q_wdata)
  );

  psti_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_data  (q_wdata),
    .full     (full),
    .rd_en    (q_rd),
    .rd_valid (q_rd_valid),
    .rd_data  (q_rdata)
  );

  // The back part owns both per-pixel stores, the pixel stages, the
  // divider for the running mean and the result queue.
  psti_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_rd_valid),
    .head       (q_rdata),
    .head_pop   (q_rd),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

  assign result_pixel  = out_data.pixel;
  assign out_frame_end = out_data.last;

endmodule
